@@ design/sjq_pkg.sv @@
`timescale 1ns / 1ps

package sjq_pkg;

    // op codes carried in s_axis_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes carried in m_axis_tuser
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_HEAD,
        S_POP_RD,
        S_POP_WR,
        S_OUT
    } t_sjq_state;

endpackage

@@ design/sjq_ram.sv @@
`timescale 1ns / 1ps

// Entry store: one write port, one read port with registered read data.
module sjq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sorted_priority_job_queue_unit.sv @@
`timescale 1ns / 1ps

// Sorted priority job queue: holds up to QUEUE_DEPTH jobs (priority + tag) in a
// single-port-read RAM kept in descending priority order, head at address zero.
// A push (tuser = 0) walks from the tail toward the head, moving each stored job
// whose priority is not higher one slot back, then writes the new job; equal
// priorities therefore come out newest first. A pop (tuser = 1) returns the head
// and moves the rest up one slot. Each word in gives exactly one word out with a
// status (0 pushed, 1 popped, 2 pop on empty, 3 push rejected full) and the
// occupancy after the operation. The block takes one word at a time: s_axis_tready
// is high only while idle. Every moved entry costs a RAM read, then a compare and
// write back; a push moves back at most QUEUE_DEPTH-1 jobs, and a pop reads the
// head, then moves each remaining job up one slot. Full and empty cases go
// straight to the result. The result then holds until taken, and the next word is
// accepted the cycle after.
module sorted_priority_job_queue_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TAG_BITS      = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,

    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // job_priority, job_tag, zero pad
    input  logic [((PRIORITY_BITS+TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic                                   s_axis_tuser,

    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_priority, out_tag, occupancy, zero pad
    output logic [((PRIORITY_BITS+TAG_BITS+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0]                             m_axis_tuser
);

    localparam int IDX_W      = $clog2(QUEUE_DEPTH);
    localparam int OCC_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W      = PRIORITY_BITS + TAG_BITS;
    localparam int OUT_DATA_W = ((PRIORITY_BITS + TAG_BITS + OCC_W + 7) / 8) * 8;
    localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(QUEUE_DEPTH);

    sjq_pkg::t_sjq_state r_state, n_state;

    logic [OCC_W-1:0]         r_count, n_count;
    logic [OCC_W-1:0]         r_idx, n_idx;
    logic [PRIORITY_BITS-1:0] r_new_prio, n_new_prio;
    logic [TAG_BITS-1:0]      r_new_tag, n_new_tag;
    logic [1:0]               r_status, n_status;
    logic [PRIORITY_BITS-1:0] r_out_prio, n_out_prio;
    logic [TAG_BITS-1:0]      r_out_tag, n_out_tag;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [ENT_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ENT_W-1:0]         ram_rdata;

    logic                     in_acc;
    logic                     out_acc;
    logic [OCC_W-1:0]         idx_m1;
    logic                     idx_zero;
    logic                     pop_done;
    logic                     cmp_le;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [TAG_BITS-1:0]      rd_tag;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign idx_m1   = r_idx - OCC_W'(1);
    assign idx_zero = (r_idx == '0);
    assign pop_done = (r_idx == r_count);
    assign rd_prio  = ram_rdata[PRIORITY_BITS-1:0];
    assign rd_tag   = ram_rdata[ENT_W-1:PRIORITY_BITS];

    // shared compare unit: stored job moves back when its priority is not higher
    assign cmp_le = (rd_prio <= r_new_prio);

    sjq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sjq_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == sjq_pkg::OP_PUSH) begin
                        n_state = (r_count == FULL_CNT) ? sjq_pkg::S_OUT : sjq_pkg::S_PUSH_RD;
                    end else begin
                        n_state = (r_count == '0) ? sjq_pkg::S_OUT : sjq_pkg::S_POP_HEAD;
                    end
                end
            end
            sjq_pkg::S_PUSH_RD: begin
                n_state = idx_zero ? sjq_pkg::S_OUT : sjq_pkg::S_PUSH_CMP;
            end
            sjq_pkg::S_PUSH_CMP: begin
                n_state = cmp_le ? sjq_pkg::S_PUSH_RD : sjq_pkg::S_OUT;
            end
            sjq_pkg::S_POP_HEAD: n_state = sjq_pkg::S_POP_RD;
            sjq_pkg::S_POP_RD: begin
                n_state = pop_done ? sjq_pkg::S_OUT : sjq_pkg::S_POP_WR;
            end
            sjq_pkg::S_POP_WR: n_state = sjq_pkg::S_POP_RD;
            sjq_pkg::S_OUT: begin
                if (out_acc) begin
                    n_state = sjq_pkg::S_IDLE;
                end
            end
            default: n_state = sjq_pkg::S_IDLE;
        endcase
    end

    // datapath control and RAM access
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_idx[IDX_W-1:0];
        ram_wdata  = {r_new_tag, r_new_prio};
        ram_raddr  = '0;
        n_idx      = r_idx;
        n_count    = r_count;
        n_new_prio = r_new_prio;
        n_new_tag  = r_new_tag;
        n_status   = r_status;
        n_out_prio = r_out_prio;
        n_out_tag  = r_out_tag;
        case (r_state)
            sjq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_new_prio = s_axis_tdata[PRIORITY_BITS-1:0];
                    n_new_tag  = s_axis_tdata[ENT_W-1:PRIORITY_BITS];
                    n_out_prio = '0;
                    n_out_tag  = '0;
                    if (s_axis_tuser == sjq_pkg::OP_PUSH) begin
                        n_idx    = r_count;
                        n_status = sjq_pkg::ST_FULL;
                    end else begin
                        n_idx    = OCC_W'(1);
                        n_status = sjq_pkg::ST_EMPTY;
                    end
                end
            end
            sjq_pkg::S_PUSH_RD: begin
                if (idx_zero) begin
                    // reached the head: new job goes to slot zero
                    ram_we   = 1'b1;
                    n_count  = r_count + OCC_W'(1);
                    n_status = sjq_pkg::ST_PUSHED;
                end else begin
                    ram_raddr = idx_m1[IDX_W-1:0];
                end
            end
            sjq_pkg::S_PUSH_CMP: begin
                ram_we = 1'b1;
                if (cmp_le) begin
                    ram_wdata = ram_rdata;
                    n_idx     = idx_m1;
                end else begin
                    n_count  = r_count + OCC_W'(1);
                    n_status = sjq_pkg::ST_PUSHED;
                end
            end
            sjq_pkg::S_POP_HEAD: begin
                n_out_prio = rd_prio;
                n_out_tag  = rd_tag;
                n_status   = sjq_pkg::ST_POPPED;
            end
            sjq_pkg::S_POP_RD: begin
                if (pop_done) begin
                    n_count = r_count - OCC_W'(1);
                end else begin
                    ram_raddr = r_idx[IDX_W-1:0];
                end
            end
            sjq_pkg::S_POP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_idx     = r_idx + OCC_W'(1);
            end
            sjq_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sjq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_new_prio <= n_new_prio;
        r_new_tag  <= n_new_tag;
        r_status   <= n_status;
        r_out_prio <= n_out_prio;
        r_out_tag  <= n_out_tag;
    end

    // ports
    assign s_axis_tready = (r_state == sjq_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == sjq_pkg::S_OUT);
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_DATA_W'({r_count, r_out_tag, r_out_prio});

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy above queue depth");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("ready again right after accept");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == sjq_pkg::ST_FULL) |-> (r_count == FULL_CNT))
        else $error("full status with free slots");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == sjq_pkg::ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with jobs held");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TAG_BITS      = 16;
    localparam int STALL_LIMIT   = 1000;   // cycles without any handshake on either port
    localparam int DRAIN_CYCLES  = 40;     // longer than the slowest pop

    // expected fields of one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  prio;
        logic [15:0] tag;
        logic [4:0]  occ;
    } t_job_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // job_priority, job_tag
    logic [23:0] s_axis_tdata = '0;
    // op
    logic        s_axis_tuser = sjq_pkg::OP_PUSH;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_priority, out_tag, occupancy, zero pad
    logic [31:0] m_axis_tdata;
    // status
    logic [1:0]  m_axis_tuser;

    // shadow copy of the sorted job store
    logic [7:0]  held_prio [QUEUE_DEPTH];
    logic [15:0] held_tag  [QUEUE_DEPTH];
    int          held_count = 0;

    t_job_result pending_results [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b0;
    int          rx_stall = 0;

    sorted_priority_job_queue_unit #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PRIORITY_BITS(PRIORITY_BITS),
        .TAG_BITS     (TAG_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sorted insert / head removal, one result per word
    function automatic t_job_result predict_job(logic op, logic [7:0] prio,
                                                logic [15:0] tag);
        t_job_result r;
        int          pos;
        int          k;
        r = '0;
        if (op == sjq_pkg::OP_PUSH) begin
            if (held_count >= QUEUE_DEPTH) begin
                r.status = sjq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && prio < held_prio[pos]) pos++;
                for (k = held_count; k > pos; k--) begin
                    held_prio[k] = held_prio[k-1];
                    held_tag[k]  = held_tag[k-1];
                end
                held_prio[pos] = prio;
                held_tag[pos]  = tag;
                held_count++;
                r.status = sjq_pkg::ST_PUSHED;
            end
        end else begin
            if (held_count == 0) begin
                r.status = sjq_pkg::ST_EMPTY;
            end else begin
                r.prio = held_prio[0];
                r.tag  = held_tag[0];
                for (k = 1; k < held_count; k++) begin
                    held_prio[k-1] = held_prio[k];
                    held_tag[k-1]  = held_tag[k];
                end
                held_count--;
                r.status = sjq_pkg::ST_POPPED;
            end
        end
        r.occ = held_count[4:0];
        return r;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_priority(int mode);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(120, 123));     // lots of equal priorities
            default: begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd254;
                    default: return 8'd255;
                endcase
            end
        endcase
    endfunction

    // drive one word and wait for it to be taken; valid stays high if no gap follows
    task automatic send_job(logic op, logic [7:0] prio, logic [15:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {tag, prio};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_job(op, prio, tag));
    endtask

    task automatic send_random(int push_pct, int prio_mode);
        logic op;
        op = ($urandom_range(0, 99) < push_pct) ? sjq_pkg::OP_PUSH : sjq_pkg::OP_POP;
        send_job(op, pick_priority(prio_mode), 16'($urandom_range(0, 65535)));
    endtask

    // empty pop, field extremes, equal priorities at head, middle and tail
    task automatic test_directed();
        idle_on = 1'b0;
        send_job(sjq_pkg::OP_POP,  8'h00, 16'hFFFF);
        send_job(sjq_pkg::OP_PUSH, 8'h00, 16'h0000);
        send_job(sjq_pkg::OP_PUSH, 8'hFF, 16'hFFFF);
        send_job(sjq_pkg::OP_PUSH, 8'h80, 16'h5555);
        send_job(sjq_pkg::OP_PUSH, 8'h80, 16'hAAAA);
        send_job(sjq_pkg::OP_PUSH, 8'h80, 16'h0001);
        send_job(sjq_pkg::OP_PUSH, 8'h00, 16'h1234);
        send_job(sjq_pkg::OP_PUSH, 8'hFF, 16'h00FF);
        repeat (8) send_job(sjq_pkg::OP_POP, 8'hFF, 16'hFFFF);
    endtask

    // fill past full, then drain past empty
    task automatic test_fill_and_drain(bit with_idle);
        int mode;
        idle_on = with_idle;
        mode = $urandom_range(0, 2);
        repeat (QUEUE_DEPTH + 3) send_random(100, mode);
        repeat (QUEUE_DEPTH + 2) send_random(0, mode);
    endtask

    // phases of push-heavy, balanced and pop-heavy traffic
    task automatic test_random_mix(int n_words);
        int sent;
        int phase_len;
        int push_pct;
        int mode;
        sent = 0;
        while (sent < n_words) begin
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 25;
                1: push_pct = 50;
                default: push_pct = 75;
            endcase
            mode = $urandom_range(0, 2);
            repeat (phase_len) send_random(push_pct, mode);
            sent += phase_len;
        end
    endtask

    // receiver side stalls
    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall      <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                        : $urandom_range(8, 40);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_job_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, actual status %0h data %0h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status",    32'(want.status), 32'(m_axis_tuser));
                check_field("priority",  32'(want.prio),   32'(m_axis_tdata[7:0]));
                check_field("tag",       32'(want.tag),    32'(m_axis_tdata[23:8]));
                check_field("occupancy", 32'(want.occ),    32'(m_axis_tdata[28:24]));
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_drain(1'b0);
        test_random_mix(420);
        test_fill_and_drain(1'b1);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
